FILE: hdl/per_cpu_sample_ring_overwrite_core_defines.svh
// Assertion macros shared by the ring core.
`ifndef PER_CPU_SAMPLE_RING_OVERWRITE_CORE_DEFINES_SVH
`define PER_CPU_SAMPLE_RING_OVERWRITE_CORE_DEFINES_SVH

`ifndef SYNTH
`define PCSRO_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcsro assertion failed");
`define PCSRO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcsro assertion failed");
`else
`define PCSRO_ASSERT_SAME(label, ante, cons)
`define PCSRO_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/pcsro_pkg.sv
package pcsro_pkg;

   localparam int OP_W      = 2;
   localparam int CPU_IDX_W = 3;
   localparam int TIME_W    = 64;
   localparam int UTIL_W    = 11;
   localparam int LOAD_W    = 20;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_DRAIN = 2'd2
   } pcsro_op_type;

   localparam logic STATUS_RING  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RESP = 1'b1
   } pcsro_state_type;

   typedef struct packed {
      logic [TIME_W-1:0] sample_time;
      logic [UTIL_W-1:0] util_mean;
      logic [UTIL_W-1:0] util_pred;
      logic [LOAD_W-1:0] load_mean;
      logic [UTIL_W-1:0] runq_mean;
   } pcsro_sample_type;

endpackage

FILE: hdl/pcsro_req_if.sv
interface pcsro_req_if import pcsro_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [CPU_IDX_W-1:0] cpu_index;
   logic [TIME_W-1:0]    sample_time;
   logic [UTIL_W-1:0]    util_average;
   logic [UTIL_W-1:0]    util_estimate;
   logic [LOAD_W-1:0]    load_average;
   logic [UTIL_W-1:0]    runnable_average;

   modport source (output valid, op, cpu_index, sample_time, util_average, util_estimate,
                   load_average, runnable_average, input ready);
   modport sink (input valid, op, cpu_index, sample_time, util_average, util_estimate,
                 load_average, runnable_average, output ready);
endinterface

FILE: hdl/pcsro_rsp_if.sv
interface pcsro_rsp_if import pcsro_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic [TIME_W-1:0] out_time;
   logic [UTIL_W-1:0] out_util_avg;
   logic [UTIL_W-1:0] out_util_est;
   logic [LOAD_W-1:0] out_load_avg;
   logic [UTIL_W-1:0] out_runnable_avg;
   logic [UTIL_W-1:0] freq_request;

   modport source (output valid, status, out_time, out_util_avg, out_util_est, out_load_avg,
                   out_runnable_avg, freq_request, input ready);
   modport sink (input valid, status, out_time, out_util_avg, out_util_est, out_load_avg,
                 out_runnable_avg, freq_request, output ready);
endinterface

FILE: hdl/per_cpu_sample_ring_overwrite_core.sv
// Per-CPU sample ring with overwrite of the oldest entry.
// The request channel carries one operation per transfer: push a sample, pop the
// oldest sample, or drain the ring and return the newest sample together with a
// frequency request. A push produces no response; a pop or drain produces exactly
// one transfer on the response channel. Requests naming a CPU at or above
// NUM_CPUS, and the unused operation code, are taken and dropped silently.
// A push finishes in the cycle it is accepted, so pushes stream at one per cycle
// while idle. A pop or drain is taken in the idle state, where the slot RAM
// registers its read data; the response-building state then moves that data into
// the response register. Requests are refused in that state, which holds while
// the response register is still full and the receiver holds ready low. A waiting
// response does not block the next request once captured in the response register.
// Synchronous reset empties every ring and clears the cached newest samples; the
// slot RAM is not cleared, since only slots between tail and head are ever read.
module per_cpu_sample_ring_overwrite_core import pcsro_pkg::*; #(
   parameter int RING_DEPTH = 16,
   parameter int NUM_CPUS   = 8
) (
   input logic         clock,
   input logic         reset,
   pcsro_req_if.sink   req_chan,
   pcsro_rsp_if.source rsp_chan
);

`include "per_cpu_sample_ring_overwrite_core_defines.svh"

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SLOTS  = NUM_CPUS * RING_DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

   // Ring pointers advance with wraparound at the configured depth.
   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_PTR : p - 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [CPU_W-1:0] c,
                                                   input logic [PTR_W-1:0] p);
      return ADDR_W'(32'(c) * 32'(RING_DEPTH) + 32'(p));
   endfunction

   // Per-CPU control state and the cached newest sample live in flops.
   logic [PTR_W-1:0]  head_ff [NUM_CPUS];
   logic [PTR_W-1:0]  tail_ff [NUM_CPUS];
   pcsro_sample_type  last_ff [NUM_CPUS];

   pcsro_state_type   state_ff, state_in;
   logic [CPU_W-1:0]  cpu_ff;
   logic              drain_ff;
   logic              empty_ff;

   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   pcsro_sample_type  rsp_sample_ff;
   logic [UTIL_W-1:0] rsp_freq_ff;

   logic              accept;
   logic              cpu_ok;
   logic              take;
   logic [CPU_W-1:0]  cpu_sel;
   logic [PTR_W-1:0]  head_cur;
   logic [PTR_W-1:0]  tail_cur;
   logic [PTR_W-1:0]  head_nxt;
   logic              ring_empty;
   logic              is_push;
   logic              is_pop;
   logic              is_drain;
   logic              load_rsp;
   logic              req_ready;

   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   pcsro_sample_type  ram_wdata;
   pcsro_sample_type  ram_rdata;

   pcsro_sample_type  rsp_sample;
   logic [UTIL_W-1:0] rsp_freq;

   // Request decode.
   assign accept     = req_chan.valid && req_ready;
   assign cpu_ok     = 32'(req_chan.cpu_index) < 32'(NUM_CPUS);
   assign take       = accept && cpu_ok;
   assign cpu_sel    = CPU_W'(req_chan.cpu_index);
   assign head_cur   = head_ff[cpu_sel];
   assign tail_cur   = tail_ff[cpu_sel];
   assign head_nxt   = wrap_next(head_cur);
   assign ring_empty = (head_cur == tail_cur);
   assign is_push    = (req_chan.op == OP_PUSH);
   assign is_pop     = (req_chan.op == OP_POP);
   assign is_drain   = (req_chan.op == OP_DRAIN);

   // A push writes its slot at once. A pop reads the slot at tail, a drain the
   // slot just behind head. Writes and reads fall in different cycles, so the RAM
   // never sees a read of an entry in the cycle that entry is written.
   assign ram_we    = take && is_push;
   assign ram_waddr = slot_addr(cpu_sel, head_cur);
   assign ram_wdata = '{sample_time: req_chan.sample_time,
                        util_mean:   req_chan.util_average,
                        util_pred:   req_chan.util_estimate,
                        load_mean:   req_chan.load_average,
                        runq_mean:   req_chan.runnable_average};
   assign ram_re    = take && (is_pop || is_drain) && !ring_empty;
   assign ram_raddr = slot_addr(cpu_sel, is_drain ? wrap_prev(head_cur) : tail_cur);

   pcsro_slot_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (ADDR_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Pointer and cache update. On a push into a full ring, tail steps forward
   // first, which drops the oldest sample; head then steps past the new one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else if (take) begin
         if (is_push) begin
            head_ff[cpu_sel] <= head_nxt;
            last_ff[cpu_sel] <= ram_wdata;
            if (head_nxt == tail_cur) begin
               tail_ff[cpu_sel] <= wrap_next(tail_cur);
            end
         end else if (is_pop && !ring_empty) begin
            tail_ff[cpu_sel] <= wrap_next(tail_cur);
         end else if (is_drain && !ring_empty) begin
            tail_ff[cpu_sel] <= head_cur;
         end
      end
   end

   // Context of the request whose response is being built.
   always_ff @(posedge clock) begin
      if (accept) begin
         cpu_ff   <= cpu_sel;
         drain_ff <= is_drain;
         empty_ff <= ring_empty;
      end
   end

   // Control sequencer: idle, or building a response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (take && (is_pop || is_drain)) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // An empty ring answers from the cache with a zero request. The cache cannot
   // change while a response is being built, since no request is taken then.
   always_comb begin
      if (empty_ff) begin
         rsp_sample = last_ff[cpu_ff];
         rsp_freq   = '0;
      end else begin
         rsp_sample = ram_rdata;
         if (!drain_ff) begin
            rsp_freq = '0;
         end else if (ram_rdata.util_pred != '0) begin
            rsp_freq = ram_rdata.util_pred;
         end else begin
            rsp_freq = ram_rdata.util_mean;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= empty_ff ? STATUS_EMPTY : STATUS_RING;
         rsp_sample_ff <= rsp_sample;
         rsp_freq_ff   <= rsp_freq;
      end
   end

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.out_time         = rsp_sample_ff.sample_time;
   assign rsp_chan.out_util_avg     = rsp_sample_ff.util_mean;
   assign rsp_chan.out_util_est     = rsp_sample_ff.util_pred;
   assign rsp_chan.out_load_avg     = rsp_sample_ff.load_mean;
   assign rsp_chan.out_runnable_avg = rsp_sample_ff.runq_mean;
   assign rsp_chan.freq_request     = rsp_freq_ff;

   // A pop or drain for a valid CPU always moves on to building its response.
   `PCSRO_ASSERT_NEXT(a_resp_follows, take && (is_pop || is_drain), state_ff == ST_RESP)
   // After a push the addressed ring holds at least one sample.
   `PCSRO_ASSERT_NEXT(a_push_nonempty, take && is_push, head_ff[cpu_ff] != tail_ff[cpu_ff])
   // A new response only appears out of the response-building cycle.
   `PCSRO_ASSERT_SAME(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff == ST_RESP))
   // A response from the ring carries no request unless it came from a drain.
   `PCSRO_ASSERT_NEXT(a_pop_no_freq, load_rsp && !drain_ff, rsp_freq_ff == '0)

endmodule

FILE: hdl/pcsro_slot_ram.sv
// Sample slot storage: one write port, one read port, registered read data.
module pcsro_slot_ram import pcsro_pkg::*; #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pcsro_sample_type  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pcsro_sample_type  rd_data
);

   pcsro_sample_type slot_mem_ff [DEPTH];
   pcsro_sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/pcsro_ring_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the sample ring core, keeps its own copy of every
// per-CPU ring and cached newest sample, and compares each response transfer
// against the oldest outstanding prediction.
module pcsro_ring_checker import pcsro_pkg::*; #(
   parameter int RING_DEPTH = 16,
   parameter int NUM_CPUS   = 8
) (
   input  logic clock,
   input  logic reset,
   pcsro_req_if req_mon,
   pcsro_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   reply_count,
   output int   empty_reply_count,
   output int   overwrite_count
);

   typedef struct {
      logic              status;
      pcsro_sample_type  sample;
      logic [UTIL_W-1:0] freq;
   } ring_reply_type;

   pcsro_sample_type slot_store [NUM_CPUS][RING_DEPTH];
   pcsro_sample_type newest_sample [NUM_CPUS];
   int unsigned      head_slot [NUM_CPUS];
   int unsigned      tail_slot [NUM_CPUS];
   ring_reply_type   reply_queue [$];

   int               failures;
   int               replies_seen;
   int               empties;
   int               overwrites;
   pcsro_sample_type req_sample;
   ring_reply_type   got_reply;
   ring_reply_type   want_reply;

   function automatic int unsigned slot_after(int unsigned p);
      return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
   endfunction

   function automatic int unsigned slot_before(int unsigned p);
      return (p == 0) ? RING_DEPTH - 1 : p - 1;
   endfunction

   function automatic void check_field(string field_name, logic [TIME_W-1:0] expected,
                                       logic [TIME_W-1:0] actual);
      if (actual !== expected) begin
         failures++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, expected, actual);
      end
   endfunction

   function automatic void predict_request(logic [OP_W-1:0] op, int unsigned cpu,
                                           pcsro_sample_type s);
      int unsigned    head;
      int unsigned    tail;
      ring_reply_type reply;
      if (cpu >= NUM_CPUS) return;
      head = head_slot[cpu];
      tail = tail_slot[cpu];
      if (op == OP_PUSH) begin
         // A full ring gives up its oldest entry so that head never passes tail.
         if (slot_after(head) == tail) begin
            tail_slot[cpu] = slot_after(tail);
            overwrites++;
         end
         slot_store[cpu][head] = s;
         newest_sample[cpu]    = s;
         head_slot[cpu]        = slot_after(head);
         return;
      end
      if (op != OP_POP && op != OP_DRAIN) return;
      if (head == tail) begin
         reply.status = STATUS_EMPTY;
         reply.sample = newest_sample[cpu];
         reply.freq   = '0;
         empties++;
      end else if (op == OP_POP) begin
         reply.status   = STATUS_RING;
         reply.sample   = slot_store[cpu][tail];
         reply.freq     = '0;
         tail_slot[cpu] = slot_after(tail);
      end else begin
         reply.status   = STATUS_RING;
         reply.sample   = slot_store[cpu][slot_before(head)];
         reply.freq     = (reply.sample.util_pred != '0) ? reply.sample.util_pred
                                                         : reply.sample.util_mean;
         tail_slot[cpu] = head;
      end
      reply_queue.push_back(reply);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            head_slot[c]     = 0;
            tail_slot[c]     = 0;
            newest_sample[c] = '0;
         end
         reply_queue.delete();
         failures     = 0;
         replies_seen = 0;
         empties      = 0;
         overwrites   = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_reply.status             = rsp_mon.status;
            got_reply.sample.sample_time = rsp_mon.out_time;
            got_reply.sample.util_mean   = rsp_mon.out_util_avg;
            got_reply.sample.util_pred   = rsp_mon.out_util_est;
            got_reply.sample.load_mean   = rsp_mon.out_load_avg;
            got_reply.sample.runq_mean   = rsp_mon.out_runnable_avg;
            got_reply.freq               = rsp_mon.freq_request;
            replies_seen++;
            if (reply_queue.size() == 0) begin
               failures++;
               $error("response transfer arrived with no request outstanding");
            end else begin
               want_reply = reply_queue.pop_front();
               check_field("status", TIME_W'(want_reply.status),
                           TIME_W'(got_reply.status));
               check_field("out_time", want_reply.sample.sample_time,
                           got_reply.sample.sample_time);
               check_field("out_util_avg", TIME_W'(want_reply.sample.util_mean),
                           TIME_W'(got_reply.sample.util_mean));
               check_field("out_util_est", TIME_W'(want_reply.sample.util_pred),
                           TIME_W'(got_reply.sample.util_pred));
               check_field("out_load_avg", TIME_W'(want_reply.sample.load_mean),
                           TIME_W'(got_reply.sample.load_mean));
               check_field("out_runnable_avg", TIME_W'(want_reply.sample.runq_mean),
                           TIME_W'(got_reply.sample.runq_mean));
               check_field("freq_request", TIME_W'(want_reply.freq),
                           TIME_W'(got_reply.freq));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            req_sample.sample_time = req_mon.sample_time;
            req_sample.util_mean   = req_mon.util_average;
            req_sample.util_pred   = req_mon.util_estimate;
            req_sample.load_mean   = req_mon.load_average;
            req_sample.runq_mean   = req_mon.runnable_average;
            predict_request(req_mon.op, int'(req_mon.cpu_index), req_sample);
         end
      end
      fail_count        <= failures;
      pending_count     <= reply_queue.size();
      reply_count       <= replies_seen;
      empty_reply_count <= empties;
      overwrite_count   <= overwrites;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

// Regression for the per-CPU sample ring core.
// This module only produces stimulus and gives the verdict. All prediction and
// comparison happens in the checker instance, which watches the same two channel
// interfaces that connect the testbench to the block.
module tb_top;
   import pcsro_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int NUM_CPUS   = 8;

   // The fourth operation code has no meaning; the block must take it and drop it.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Counted requests (the ignored opcode does not count) to issue in total.
   localparam int ITEM_TARGET  = 950;
   // From this many requests on, neither side inserts idle cycles.
   localparam int SETTLE_FROM  = 840;
   // The limit lies far above what the slowest correct run needs.
   localparam int CYCLE_LIMIT  = 400000;
   // Cycles to keep watching for stray responses once nothing is outstanding.
   localparam int DRAIN_CYCLES = 8;

   logic clock;
   logic reset = 1'b1;

   pcsro_req_if req_chan ();
   pcsro_rsp_if rsp_chan ();

   int fail_count;
   int pending_count;
   int reply_count;
   int empty_reply_count;
   int overwrite_count;

   int          request_count = 0;
   bit          settle_phase  = 1'b0;
   int unsigned cycle_count   = 0;

   per_cpu_sample_ring_overwrite_core #(
      .RING_DEPTH(RING_DEPTH),
      .NUM_CPUS  (NUM_CPUS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   pcsro_ring_checker #(
      .RING_DEPTH(RING_DEPTH),
      .NUM_CPUS  (NUM_CPUS)
   ) ring_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .reply_count      (reply_count),
      .empty_reply_count(empty_reply_count),
      .overwrite_count  (overwrite_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Utilization values are mostly inside the 0..1024 capacity scale. Zero is
   // favored so that drains often fall back from the utilization estimate to the
   // utilization average, and now and then the full 11-bit width is used to show
   // that values above the stated range are carried unchanged.
   function automatic logic [UTIL_W-1:0] random_util();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return UTIL_W'($urandom_range(0, 2047));
         default: return UTIL_W'($urandom_range(0, 1024));
      endcase
   endfunction

   function automatic pcsro_sample_type random_sample();
      pcsro_sample_type s;
      s.sample_time = {$urandom, $urandom};
      s.util_mean   = random_util();
      s.util_pred   = random_util();
      s.load_mean   = LOAD_W'($urandom_range(0, 20'hFFFFF));
      s.runq_mean   = random_util();
      return s;
   endfunction

   // Presents one request and holds it until the block takes it. Valid is only
   // lowered when an idle gap is inserted, so back-to-back requests keep valid
   // high and each time step sees at most one assignment to it.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [CPU_IDX_W-1:0] cpu,
                               input pcsro_sample_type s);
      int gap;
      gap = 0;
      if (!settle_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.op               <= op;
      req_chan.cpu_index        <= cpu;
      req_chan.sample_time      <= s.sample_time;
      req_chan.util_average     <= s.util_mean;
      req_chan.util_estimate    <= s.util_pred;
      req_chan.load_average     <= s.load_mean;
      req_chan.runnable_average <= s.runq_mean;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op != OP_UNUSED) request_count++;
   endtask

   // Response side back-pressure. Ready drops now and then between high stretches
   // of random length, and stays high once the run settles.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!settle_phase && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(0, 24)) @(posedge clock);
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_count);
         $display("per_cpu_sample_ring_overwrite_core regression: fail");
         $finish;
      end
   end

   initial begin
      pcsro_sample_type      edge_sample;
      logic [OP_W-1:0]       op;
      logic [CPU_IDX_W-1:0]  cpu;
      int                    pick;

      req_chan.valid            <= 1'b0;
      req_chan.op               <= OP_PUSH;
      req_chan.cpu_index        <= '0;
      req_chan.sample_time      <= '0;
      req_chan.util_average     <= '0;
      req_chan.util_estimate    <= '0;
      req_chan.load_average     <= '0;
      req_chan.runnable_average <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Reading an untouched ring must return the all-zero cached
      // sample with the empty status, for both pop and drain.
      send_request(OP_POP, 3'd0, random_sample());
      send_request(OP_DRAIN, 3'd5, random_sample());

      // All fields at their widest values, then a drain whose request comes
      // from a nonzero utilization estimate.
      edge_sample.sample_time = '1;
      edge_sample.util_mean   = '1;
      edge_sample.util_pred   = '1;
      edge_sample.load_mean   = '1;
      edge_sample.runq_mean   = '1;
      send_request(OP_PUSH, 3'd0, edge_sample);
      send_request(OP_DRAIN, 3'd0, random_sample());

      // A zero estimate makes the drain fall back to the average. The pop after
      // the drain finds the ring empty and must return this sample from the cache.
      edge_sample.sample_time = '0;
      edge_sample.util_mean   = UTIL_W'(1024);
      edge_sample.util_pred   = '0;
      edge_sample.load_mean   = '0;
      edge_sample.runq_mean   = '0;
      send_request(OP_PUSH, 3'd0, edge_sample);
      send_request(OP_DRAIN, 3'd0, random_sample());
      send_request(OP_POP, 3'd0, random_sample());

      // The unused opcode must be swallowed without a response.
      send_request(OP_UNUSED, 3'd3, random_sample());

      // Sixteen pushes into a ring that holds fifteen: the last one overwrites
      // the oldest entry, so the pop must return the second sample pushed.
      repeat (RING_DEPTH) send_request(OP_PUSH, 3'd7, random_sample());
      send_request(OP_POP, 3'd7, random_sample());

      // Random part, built from episodes aimed at one CPU so that rings fill up,
      // overflow and wrap, mixed with short stretches of scattered requests.
      while (request_count < ITEM_TARGET) begin
         if (request_count >= SETTLE_FROM) settle_phase <= 1'b1;
         cpu = CPU_IDX_W'($urandom_range(0, NUM_CPUS - 1));
         case ($urandom_range(0, 5))
            0, 1: repeat ($urandom_range(4, 22)) send_request(OP_PUSH, cpu, random_sample());
            2: repeat ($urandom_range(1, 8)) send_request(OP_POP, cpu, random_sample());
            3: send_request(OP_DRAIN, cpu, random_sample());
            default: begin
               repeat ($urandom_range(1, 10)) begin
                  pick = $urandom_range(0, 19);
                  if (pick < 10) op = OP_PUSH;
                  else if (pick < 15) op = OP_POP;
                  else if (pick < 19) op = OP_DRAIN;
                  else op = OP_UNUSED;
                  send_request(op, CPU_IDX_W'($urandom_range(0, NUM_CPUS - 1)),
                               random_sample());
               end
            end
         endcase
      end
      req_chan.valid <= 1'b0;

      // The checker publishes its outstanding count through a register, so look only
      // from the next edge on. Then keep watching for stray responses a while.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests across %0d CPU rings; compared %0d responses,",
               request_count, NUM_CPUS, reply_count);
      $display("%0d of them from empty rings, with %0d oldest-entry overwrites on push.",
               empty_reply_count, overwrite_count);
      if (fail_count == 0) begin
         $display("per_cpu_sample_ring_overwrite_core regression: pass");
      end else begin
         $display("per_cpu_sample_ring_overwrite_core regression: fail");
      end
      $finish;
   end

endmodule
